// File: rtl/lpht_pkg.sv
package lpht_pkg;

    localparam int TABLE_SLOTS_DEF = 32;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 31;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 5;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERWROTE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HIT       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISS      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADOP     = 3'd4;

endpackage

// File: rtl/linear_probe_hash_table.sv
// A request passes the reciprocal modulo pipeline, then probes 1 to TABLE_SLOTS slots
// (one probe a cycle) and is then registered for output; an invalid op skips both steps.
// Only one request is in flight at a time: a new one is taken after the last result is
// loaded into the output register, which waits while an earlier result is not taken.
// Reset: asynchronous, active low; afterwards a clearing pass over all TABLE_SLOTS slots
// empties the table before the first request is taken.
module linear_probe_hash_table #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lpht_pkg::OP_W-1:0]     op,
    input  logic [lpht_pkg::KEY_W-1:0]    key,
    input  logic signed [lpht_pkg::VAL_W-1:0] value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lpht_pkg::STATUS_W-1:0] status,
    output logic signed [lpht_pkg::VAL_W-1:0] found_value,
    output logic [lpht_pkg::SLOT_W-1:0]   slot
);

    localparam int IW   = $clog2(TABLE_SLOTS);
    localparam int WIDE = (IW > lpht_pkg::SLOT_W) ? IW : lpht_pkg::SLOT_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_MOD    = 5'b00100,
        S_PROBE  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic                       used_mem [TABLE_SLOTS];
    logic [lpht_pkg::KEY_W-1:0] key_mem  [TABLE_SLOTS];
    logic [lpht_pkg::VAL_W-1:0] val_mem  [TABLE_SLOTS];

    logic                       used_rd_reg;
    logic [lpht_pkg::KEY_W-1:0] key_rd_reg;
    logic [lpht_pkg::VAL_W-1:0] val_rd_reg;

    logic [lpht_pkg::OP_W-1:0]  op_reg;
    logic [lpht_pkg::KEY_W-1:0] key_reg;
    logic [lpht_pkg::VAL_W-1:0] value_reg;
    logic [IW-1:0]              idx_reg, idx_next;
    logic [IW-1:0]              home_reg, home_next;
    logic [IW-1:0]              cnt_reg, cnt_next;
    logic [IW-1:0]              clr_reg, clr_next;
    logic [IW-1:0]              idx_inc;

    logic [lpht_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [lpht_pkg::VAL_W-1:0]    res_val_reg, res_val_next;
    logic [IW-1:0]                 res_slot_reg, res_slot_next;

    logic                          out_valid_reg, out_valid_next;
    logic [lpht_pkg::STATUS_W-1:0] status_reg;
    logic [lpht_pkg::VAL_W-1:0]    found_reg;
    logic [lpht_pkg::SLOT_W-1:0]   slot_reg;
    logic                          out_load;

    logic          accept;
    logic          mod_done;
    logic [IW-1:0] mod_rem;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic          wr_used_en;
    logic          wr_used_data;
    logic          wr_kv_en;
    logic [WIDE-1:0] slot_wide;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign idx_inc  = (idx_reg == LAST_IDX) ? '0 : (idx_reg + 1'b1);

    lpht_mod #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_mod (
        .clk  (clk),
        .rst_n(rst_n),
        .start(accept),
        .key  (key),
        .done (mod_done),
        .rem  (mod_rem)
    );

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        home_next       = home_reg;
        cnt_next        = cnt_reg;
        clr_next        = clr_reg;
        res_status_next = res_status_reg;
        res_val_next    = res_val_reg;
        res_slot_next   = res_slot_reg;
        rd_addr         = idx_inc;
        wr_addr         = idx_reg;
        wr_used_en      = 1'b0;
        wr_used_data    = 1'b0;
        wr_kv_en        = 1'b0;
        out_load        = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                wr_addr    = clr_reg;
                wr_used_en = 1'b1;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op == lpht_pkg::OP_INSERT || op == lpht_pkg::OP_SEARCH ||
                        op == lpht_pkg::OP_DELETE)
                    begin
                        state_next = S_MOD;
                    end
                    else
                    begin
                        res_status_next = lpht_pkg::ST_BADOP;
                        res_val_next    = '0;
                        res_slot_next   = '0;
                        state_next      = S_FINISH;
                    end
                end
            end
            S_MOD:
            begin
                rd_addr = mod_rem;
                if (mod_done)
                begin
                    idx_next   = mod_rem;
                    home_next  = mod_rem;
                    cnt_next   = '0;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                res_val_next = '0;
                res_slot_next = idx_reg;
                if (op_reg == lpht_pkg::OP_INSERT)
                begin
                    if (!used_rd_reg)
                    begin
                        wr_used_en      = 1'b1;
                        wr_used_data    = 1'b1;
                        wr_kv_en        = 1'b1;
                        res_status_next = lpht_pkg::ST_INSERTED;
                        state_next      = S_FINISH;
                    end
                    else if (cnt_reg == LAST_IDX)
                    begin
                        wr_addr         = home_reg;
                        wr_used_en      = 1'b1;
                        wr_used_data    = 1'b1;
                        wr_kv_en        = 1'b1;
                        res_status_next = lpht_pkg::ST_OVERWROTE;
                        res_slot_next   = home_reg;
                        state_next      = S_FINISH;
                    end
                end
                else
                begin
                    if (!used_rd_reg)
                    begin
                        res_status_next = lpht_pkg::ST_MISS;
                        res_slot_next   = '0;
                        state_next      = S_FINISH;
                    end
                    else if (key_rd_reg == key_reg)
                    begin
                        res_status_next = lpht_pkg::ST_HIT;
                        if (op_reg == lpht_pkg::OP_SEARCH)
                        begin
                            res_val_next = val_rd_reg;
                        end
                        else
                        begin
                            wr_used_en = 1'b1;
                        end
                        state_next = S_FINISH;
                    end
                    else if (cnt_reg == LAST_IDX)
                    begin
                        res_status_next = lpht_pkg::ST_MISS;
                        res_slot_next   = '0;
                        state_next      = S_FINISH;
                    end
                end
                if (state_next == S_PROBE)
                begin
                    idx_next = idx_inc;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op;
            key_reg   <= key;
            value_reg <= value;
        end
        idx_reg        <= idx_next;
        home_reg       <= home_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        res_val_reg    <= res_val_next;
        res_slot_reg   <= res_slot_next;
    end

    // slot memories: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_used_en)
        begin
            used_mem[wr_addr] <= wr_used_data;
        end
        if (wr_kv_en)
        begin
            key_mem[wr_addr] <= key_reg;
            val_mem[wr_addr] <= value_reg;
        end
        used_rd_reg <= used_mem[rd_addr];
        key_rd_reg  <= key_mem[rd_addr];
        val_rd_reg  <= val_mem[rd_addr];
    end

    assign slot_wide = WIDE'(res_slot_reg);

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg <= res_status_reg;
            found_reg  <= res_val_reg;
            slot_reg   <= slot_wide[lpht_pkg::SLOT_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_value = found_reg;
    assign slot        = slot_reg;

endmodule

// File: rtl/lpht_mod.sv
module lpht_mod #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lpht_pkg::KEY_W-1:0] key,
    output logic                       done,
    output logic [$clog2(TABLE_SLOTS)-1:0] rem
);

    localparam int IW      = $clog2(TABLE_SLOTS);
    localparam int RW      = IW + 1;
    localparam int RECIP_W = lpht_pkg::KEY_W + 1;
    localparam int PW      = lpht_pkg::KEY_W + RECIP_W;
    localparam int SHIFT   = lpht_pkg::KEY_W + IW;
    localparam longint unsigned RECIP_FULL = (64'd1 << SHIFT) / TABLE_SLOTS;
    localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(RECIP_FULL);
    localparam logic [RW-1:0]      SLOTS_R = RW'(TABLE_SLOTS);

    // three-stage key modulo slot count: the truncated reciprocal gives a
    // quotient low by at most one, so the low bits of key - q * slots land
    // below twice the slot count and one compare and subtract finishes it

    logic [PW-1:0] prod_reg, prod_next;
    logic [RW-1:0] klow_reg, klow_next;
    logic [RW-1:0] diff_reg, diff_next;
    logic [RW-1:0] corr;
    logic [IW-1:0] rem_reg, rem_next;
    logic          v1_reg, v1_next;
    logic          v2_reg, v2_next;
    logic          done_reg, done_next;

    always_comb
    begin
        prod_next = PW'(key) * PW'(RECIP);
        klow_next = key[RW-1:0];
        diff_next = klow_reg - prod_reg[SHIFT +: RW] * SLOTS_R;
        corr      = (diff_reg >= SLOTS_R) ? (diff_reg - SLOTS_R) : diff_reg;
        rem_next  = corr[IW-1:0];
        v1_next   = start;
        v2_next   = v1_reg && !start;
        done_next = v2_reg && !start;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= v1_next;
            v2_reg   <= v2_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        klow_reg <= klow_next;
        diff_reg <= diff_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// File: rtl/lpht_checker.sv
module lpht_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [lpht_pkg::STATUS_W-1:0] status,
    input logic [lpht_pkg::VAL_W-1:0]    found_value,
    input logic [lpht_pkg::SLOT_W-1:0]   slot
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found_value)
            && $stable(slot))
        else $error("result changed while stalled");

    // one request at a time
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready straight after a request");

    a_value_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != lpht_pkg::ST_HIT |-> found_value == '0)
        else $error("value shown without a hit");

    a_slot_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == lpht_pkg::ST_MISS || status == lpht_pkg::ST_BADOP)
            |-> slot == '0)
        else $error("slot non-zero on miss");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= lpht_pkg::ST_BADOP)
        else $error("undefined status code");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .found_value(found_value),
    .slot       (slot)
);
